[rtl/core/swr_pkg.sv]
// Shared types and constants for the splat weight renormalizer pipeline.
package swr_pkg;

    localparam int MAX_LAYERS = 8;
    localparam int NL         = 8;
    localparam int LW         = 8;
    localparam int NW         = 17;
    localparam int DW         = 9;
    localparam int TW         = 3;
    localparam int CW         = 4;

    localparam logic [LW-1:0] FULL      = 8'd255;
    localparam logic [25:0]   X_MAX     = 26'd255 << 16;
    localparam logic [25:0]   X_HALF    = 26'd32768;
    localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_LAYERS);
    localparam logic          FUNC_ADD  = 1'b0;
    localparam logic          FUNC_SET  = 1'b1;

    typedef logic [NL-1:0][LW-1:0] lanes_t;

    typedef struct packed {
        lanes_t                w;
        logic [TW-1:0]         tgt;
        logic [NL-1:0]         used;
        logic                  skip;
        logic [LW-1:0]         new_t;
        logic [LW-1:0]         prior;
        logic [DW-1:0]         dvs;
        logic [NL-1:0]         resc;
        logic [NL-1:0][NW-1:0] num;
        logic [NL-1:0][DW-1:0] rem;
        lanes_t                nlo;
        lanes_t                q;
        logic [NL-1:0]         ovf;
    } stage_t;

endpackage

[rtl/core/splat_weight_renormalizer.sv]
// Top level: pipelined edit and renormalization of one cell's layer weights.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+--------------------------------------
//  cell    | cell_valid   | cell_stall   | func, layer_count, target_layer,
//          |              |              | amount, weight_in_0..7
//  result  | result_valid | result_stall | weight_out_0..7, prior_target, skipped
//
// Eight register stages: target update, products, numerator and overflow check,
// four stages of a two-bit-per-stage restoring divider per lane, residual sum.
// One transaction per cycle while the result channel is not stalled.
// Reset (rst_n low) clears only the per-stage valid bits.
// A stalled result freezes the whole pipeline; cell_stall follows it directly.
module splat_weight_renormalizer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cell_valid,
    output logic                      cell_stall,
    input  logic                      func,
    input  logic [3:0]                layer_count,
    input  logic [2:0]                target_layer,
    input  logic [16:0]               amount,
    input  logic [7:0]                weight_in_0,
    input  logic [7:0]                weight_in_1,
    input  logic [7:0]                weight_in_2,
    input  logic [7:0]                weight_in_3,
    input  logic [7:0]                weight_in_4,
    input  logic [7:0]                weight_in_5,
    input  logic [7:0]                weight_in_6,
    input  logic [7:0]                weight_in_7,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [7:0]                weight_out_0,
    output logic [7:0]                weight_out_1,
    output logic [7:0]                weight_out_2,
    output logic [7:0]                weight_out_3,
    output logic [7:0]                weight_out_4,
    output logic [7:0]                weight_out_5,
    output logic [7:0]                weight_out_6,
    output logic [7:0]                weight_out_7,
    output logic [7:0]                prior_target,
    output logic                      skipped
);
    import swr_pkg::*;

    localparam int NS = 8;

    stage_t           st_reg [NS];
    stage_t           st_next[NS];
    logic [NS-1:0]    v_reg;
    logic             adv;

    assign adv        = !(v_reg[NS-1] && result_stall);
    assign cell_stall = v_reg[NS-1] && result_stall;

    // two restoring steps for every lane
    function automatic stage_t div_step(input stage_t s);
        stage_t         r;
        logic [DW:0]    t;
        r = s;
        for (int i = 0; i < NL; i++) begin
            for (int k = 0; k < 2; k++) begin
                t = {r.rem[i], r.nlo[i][LW-1]};
                r.nlo[i] = {r.nlo[i][LW-2:0], 1'b0};
                if (t >= {1'b0, r.dvs}) begin
                    t = t - {1'b0, r.dvs};
                    r.q[i] = {r.q[i][LW-2:0], 1'b1};
                end else begin
                    r.q[i] = {r.q[i][LW-2:0], 1'b0};
                end
                r.rem[i] = t[DW-1:0];
            end
        end
        return r;
    endfunction

    // stage 0: decode and new target weight
    always_comb begin
        logic [CW-1:0] cnt;
        logic [25:0]   x;
        lanes_t        w;
        stage_t        s;
        w   = {weight_in_7, weight_in_6, weight_in_5, weight_in_4,
               weight_in_3, weight_in_2, weight_in_1, weight_in_0};
        cnt = (layer_count > CNT_MAX) ? CNT_MAX : layer_count;
        s   = '0;
        s.w     = w;
        s.tgt   = target_layer;
        s.prior = w[target_layer];
        s.skip  = ({1'b0, target_layer} >= cnt);
        for (int i = 0; i < NL; i++) begin
            s.used[i] = (CW'(i) < cnt);
        end
        x = {2'b0, w[target_layer], 16'd0} + ({9'd0, amount} << 8) - {9'd0, amount};
        if (x > X_MAX) begin
            x = X_MAX;
        end
        x = x + X_HALF;
        s.new_t = (func == FUNC_SET) ? amount[LW-1:0] : x[23:16];
        st_next[0] = s;
    end

    // stage 1: divisor and products
    always_comb begin
        stage_t        s;
        logic [LW-1:0] oo;
        logic [LW-1:0] on;
        s  = st_reg[0];
        oo = FULL - s.prior;
        on = FULL - s.new_t;
        s.dvs = {oo, 1'b0};
        for (int i = 0; i < NL; i++) begin
            s.resc[i] = s.used[i] && (TW'(i) != s.tgt) && (oo != '0) && !s.skip;
            s.num[i]  = {16'(s.w[i]) * 16'(on), 1'b0};
        end
        st_next[1] = s;
    end

    // stage 2: rounding term, overflow check, divider seed
    always_comb begin
        stage_t        s;
        logic [NW-1:0] n;
        s = st_reg[1];
        for (int i = 0; i < NL; i++) begin
            n         = s.num[i] + NW'(s.dvs[DW-1:1]);
            s.num[i]  = n;
            s.ovf[i]  = (n >= {s.dvs, 8'd0});
            s.rem[i]  = n[NW-1:LW];
            s.nlo[i]  = n[LW-1:0];
            s.q[i]    = '0;
        end
        st_next[2] = s;
    end

    always_comb begin
        st_next[3] = div_step(st_reg[2]);
        st_next[4] = div_step(st_reg[3]);
        st_next[5] = div_step(st_reg[4]);
        st_next[6] = div_step(st_reg[5]);
    end

    // stage 7: clamp, sum of the other used layers, residual to target
    always_comb begin
        stage_t      s;
        logic [10:0] sum;
        s   = st_reg[6];
        sum = '0;
        if (!s.skip) begin
            for (int i = 0; i < NL; i++) begin
                if (s.resc[i]) begin
                    s.w[i] = s.ovf[i] ? FULL : s.q[i];
                end
                if (s.used[i] && (TW'(i) != s.tgt)) begin
                    sum = sum + 11'(s.w[i]);
                end
            end
            s.w[s.tgt] = (sum > 11'(FULL)) ? '0 : FULL - sum[LW-1:0];
        end
        st_next[7] = s;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NS-2:0], cell_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            for (int k = 0; k < NS; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign result_valid = v_reg[NS-1];
    assign weight_out_0 = st_reg[NS-1].w[0];
    assign weight_out_1 = st_reg[NS-1].w[1];
    assign weight_out_2 = st_reg[NS-1].w[2];
    assign weight_out_3 = st_reg[NS-1].w[3];
    assign weight_out_4 = st_reg[NS-1].w[4];
    assign weight_out_5 = st_reg[NS-1].w[5];
    assign weight_out_6 = st_reg[NS-1].w[6];
    assign weight_out_7 = st_reg[NS-1].w[7];
    assign prior_target = st_reg[NS-1].prior;
    assign skipped      = st_reg[NS-1].skip;

    // a skipped cell must come out with its target untouched
    a_skip_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && skipped) |-> (st_reg[NS-1].w[st_reg[NS-1].tgt] == prior_target))
        else $error("skipped cell changed its target");

    // lane 0 divider seed stays below the divisor when no overflow
    a_div_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[2] && (st_reg[2].dvs != '0) && !st_reg[2].ovf[0])
            |-> (st_reg[2].rem[0] < st_reg[2].dvs))
        else $error("divider remainder out of range");

    // frozen pipeline keeps its valid bits
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("valid bits moved during stall");

endmodule

[test/tb_splat_weight_renormalizer.sv]
// Testbench for the splat weight renormalizer: random and directed cells, queued predictions.
`timescale 1ns / 1ps

module tb_splat_weight_renormalizer;
    import swr_pkg::*;

    typedef struct {
        logic        fn;
        logic [3:0]  cnt;
        logic [2:0]  tgt;
        logic [16:0] amt;
        logic [7:0]  w [8];
    } cell_t;

    typedef struct {
        logic [7:0] w [8];
        logic [7:0] prior;
        logic       skip;
    } edit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cell_valid = 1'b0;
    logic cell_stall;
    logic func = 1'b0;
    logic [3:0] layer_count = '0;
    logic [2:0] target_layer = '0;
    logic [16:0] amount = '0;
    logic [7:0] wi [8] = '{default: 8'd0};
    logic result_valid;
    logic result_stall = 1'b0;
    logic [7:0] wo [8];
    logic [7:0] prior_target;
    logic skipped;

    cell_t pending_cells[$];
    edit_t expected_edits[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_tx = 1'b0;
    int tx_gap = 0;
    int rx_gap = 0;

    splat_weight_renormalizer dut (
        .clk(clk), .rst_n(rst_n),
        .cell_valid(cell_valid), .cell_stall(cell_stall),
        .func(func), .layer_count(layer_count), .target_layer(target_layer),
        .amount(amount),
        .weight_in_0(wi[0]), .weight_in_1(wi[1]), .weight_in_2(wi[2]),
        .weight_in_3(wi[3]), .weight_in_4(wi[4]), .weight_in_5(wi[5]),
        .weight_in_6(wi[6]), .weight_in_7(wi[7]),
        .result_valid(result_valid), .result_stall(result_stall),
        .weight_out_0(wo[0]), .weight_out_1(wo[1]), .weight_out_2(wo[2]),
        .weight_out_3(wo[3]), .weight_out_4(wo[4]), .weight_out_5(wo[5]),
        .weight_out_6(wo[6]), .weight_out_7(wo[7]),
        .prior_target(prior_target), .skipped(skipped)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic edit_t renormalize(cell_t c);
        edit_t r;
        int unsigned n, old_t, new_t, x, oo, on, nw, total;
        int adj;
        n = (c.cnt > MAX_LAYERS) ? MAX_LAYERS : c.cnt;
        for (int i = 0; i < 8; i++) r.w[i] = c.w[i];
        old_t = c.w[c.tgt];
        r.prior = old_t[7:0];
        r.skip = (c.tgt >= n);
        if (r.skip) return r;
        if (c.fn == FUNC_ADD) begin
            x = old_t * 65536 + c.amt * 255;
            if (x > 255 * 65536) x = 255 * 65536;
            new_t = (x + 32768) >> 16;
        end
        else begin
            new_t = c.amt[7:0];
        end
        r.w[c.tgt] = new_t[7:0];
        oo = 255 - old_t;
        on = 255 - new_t;
        // no rescale when the target already owned the whole cell
        if (oo > 0) begin
            for (int i = 0; i < n; i++) begin
                if (i != c.tgt) begin
                    nw = (2 * r.w[i] * on + oo) / (2 * oo);
                    r.w[i] = (nw > 255) ? 8'd255 : nw[7:0];
                end
            end
        end
        total = 0;
        for (int i = 0; i < n; i++) total += r.w[i];
        adj = int'(r.w[c.tgt]) + 255 - int'(total);
        if (adj < 0) adj = 0;
        if (adj > 255) adj = 255;
        r.w[c.tgt] = adj[7:0];
        return r;
    endfunction

    // weights of the used layers summing to 255 (a used weight is sometimes random), random content in the rest
    function automatic cell_t random_cell();
        cell_t c;
        int unsigned n, left;
        c.fn = 1'($urandom_range(0, 1));
        c.cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        c.tgt = ($urandom_range(0, 7) == 0) ? 3'($urandom) :
                3'($urandom_range(0, (c.cnt >= 1 && c.cnt <= 8) ? c.cnt - 1 : 7));
        case ($urandom_range(0, 3))
            0: c.amt = 17'($urandom);
            1: c.amt = 17'($urandom_range(0, 65536));
            2: c.amt = 17'($urandom_range(0, 4096));
            default: c.amt = 17'($urandom_range(0, 255));
        endcase
        n = (c.cnt > 8) ? 8 : c.cnt;
        left = 255;
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 9) == 0 || i >= n) c.w[i] = 8'($urandom);
            else if (i == n - 1) c.w[i] = 8'(left);
            else begin
                c.w[i] = 8'($urandom_range(0, left));
                left -= c.w[i];
            end
        end
        return c;
    endfunction

    function automatic cell_t make_cell(logic fn, logic [3:0] cnt, logic [2:0] tgt,
                                        logic [16:0] amt, logic [7:0] w0, logic [7:0] w1,
                                        logic [7:0] rest);
        cell_t c;
        c.fn = fn; c.cnt = cnt; c.tgt = tgt; c.amt = amt;
        c.w[0] = w0; c.w[1] = w1;
        for (int i = 2; i < 8; i++) c.w[i] = rest;
        return c;
    endfunction

    function automatic void add_cell(cell_t c);
        pending_cells.insert(pending_cells.size(), c);
    endfunction

    // driver
    always @(posedge clk) begin
        cell_t c;
        if (rst_n) begin
            if (!cell_valid || !cell_stall) begin
                if (tx_gap > 0 || hold_tx || pending_cells.size() == 0) begin
                    if (tx_gap > 0) tx_gap <= tx_gap - 1;
                    cell_valid <= 1'b0;
                end
                else begin
                    c = pending_cells.pop_front();
                    expected_edits.insert(expected_edits.size(), renormalize(c));
                    cell_valid <= 1'b1;
                    func <= c.fn;
                    layer_count <= c.cnt;
                    target_layer <= c.tgt;
                    amount <= c.amt;
                    for (int i = 0; i < 8; i++) wi[i] <= c.w[i];
                    if ($urandom_range(0, 3) == 0)
                        tx_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                                                               : $urandom_range(1, 2);
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        edit_t e;
        if (rst_n) begin
            if (result_valid && !result_stall) begin
                if (expected_edits.size() == 0) begin
                    $display("%0t: unexpected result transaction", $time);
                    errors++;
                end
                else begin
                    e = expected_edits.pop_front();
                    for (int i = 0; i < 8; i++)
                        if (wo[i] !== e.w[i]) begin
                            $display("%0t: weight_out_%0d expected %0d actual %0d",
                                     $time, i, e.w[i], wo[i]);
                            errors++;
                        end
                    if (prior_target !== e.prior) begin
                        $display("%0t: prior_target expected %0d actual %0d",
                                 $time, e.prior, prior_target);
                        errors++;
                    end
                    if (skipped !== e.skip) begin
                        $display("%0t: skipped expected %0d actual %0d",
                                 $time, e.skip, skipped);
                        errors++;
                    end
                end
            end
            if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                result_stall <= 1'b1;
            end
            else if ($urandom_range(0, 4) == 0) begin
                rx_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                                                       : $urandom_range(0, 2);
                result_stall <= 1'b1;
            end
            else begin
                result_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((cell_valid && !cell_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        add_cell(make_cell(FUNC_ADD, 4'd2, 3'd0, 17'd65536, 8'd0, 8'd255, 8'd0));
        add_cell(make_cell(FUNC_ADD, 4'd2, 3'd0, 17'h1FFFF, 8'd100, 8'd155, 8'd0));
        add_cell(make_cell(FUNC_ADD, 4'd2, 3'd1, 17'd0, 8'd100, 8'd155, 8'd0));
        add_cell(make_cell(FUNC_ADD, 4'd1, 3'd0, 17'd128, 8'd255, 8'd0, 8'd0));
        add_cell(make_cell(FUNC_SET, 4'd2, 3'd0, 17'h1FF00, 8'd255, 8'd0, 8'd0));
        add_cell(make_cell(FUNC_SET, 4'd3, 3'd2, 17'h000FF, 8'd40, 8'd60, 8'd155));
        add_cell(make_cell(FUNC_SET, 4'd8, 3'd7, 17'd10, 8'd255, 8'd255, 8'd255));
        add_cell(make_cell(FUNC_SET, 4'd15, 3'd7, 17'd3, 8'd30, 8'd30, 8'd32));
        add_cell(make_cell(FUNC_ADD, 4'd0, 3'd0, 17'd1000, 8'd1, 8'd2, 8'd3));
        add_cell(make_cell(FUNC_ADD, 4'd3, 3'd5, 17'd1000, 8'd1, 8'd2, 8'd252));
        add_cell(make_cell(FUNC_SET, 4'd8, 3'd3, 17'd0, 8'd0, 8'd0, 8'd42));
        add_cell(make_cell(FUNC_ADD, 4'd9, 3'd4, 17'd32768, 8'd255, 8'd255, 8'd255));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 600; i++) add_cell(random_cell());
        wait (pending_cells.size() == 0);
        // drain completely before resuming
        @(posedge clk);
        hold_tx <= 1'b1;
        wait (expected_edits.size() == 0);
        @(posedge clk);
        hold_tx <= 1'b0;
        for (int i = 0; i < 600; i++) add_cell(random_cell());
        wait (pending_cells.size() == 0);
        wait (expected_edits.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/swr_pkg.sv
rtl/core/splat_weight_renormalizer.sv
test/tb_splat_weight_renormalizer.sv
